// ===== hw/rtl/pehp_pkg.sv =====
// Shared types and constants for the polygon edge half-plane core.
`timescale 1ns / 1ps
package pehp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_W = 24;
  localparam int NORM_W = 16;
  localparam int OFFSET_W = 32;
  localparam int AREA_W = 64;
  localparam int MAG_W = 15;
  localparam int SQ_W = 30;
  localparam int L2_W = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_AREA1,
    ST_AREA2,
    ST_AREA3,
    ST_SETUP,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_OFF1,
    ST_OFF2,
    ST_OFF3,
    ST_OUT
  } core_state_t;

  typedef enum logic [1:0] {
    NS_IDLE,
    NS_DIV,
    NS_ROOT
  } norm_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } norm_ctl_t;

endpackage

// ===== hw/rtl/pehp_norm.sv =====
// Iterative unit that scales one edge component to a Q1.14 unit-normal magnitude.
`timescale 1ns / 1ps
module pehp_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pehp_pkg::SQ_W-1:0]   sq_a,
  input  logic [pehp_pkg::L2_W-1:0]   l2,
  output logic                        done,
  output logic [pehp_pkg::MAG_W-1:0]  mag
);

  pehp_pkg::norm_state_t state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic [30:0] l2_r;
  logic [30:0] rem_r;
  logic [30:0] dvd_r;
  logic [30:0] quo_r;
  logic [31:0] op_r;
  logic [31:0] res_r;
  logic [31:0] one_r;
  logic        done_r;
  logic [14:0] mag_r;

  logic [31:0] div_t;
  logic        div_ge;
  logic [31:0] rt_sum;
  logic        rt_ge;
  logic [31:0] res_step;
  logic [31:0] res_inc;

  assign div_t    = {rem_r, dvd_r[30]};
  assign div_ge   = div_t >= {1'b0, l2_r};
  assign rt_sum   = res_r + one_r;
  assign rt_ge    = op_r >= rt_sum;
  assign res_step = rt_ge ? ((res_r >> 1) + one_r) : (res_r >> 1);
  assign res_inc  = res_step + 32'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pehp_pkg::NS_IDLE: if (start) state_nxt = pehp_pkg::NS_DIV;
      pehp_pkg::NS_DIV:  if (cnt_r == 5'd0) state_nxt = pehp_pkg::NS_ROOT;
      pehp_pkg::NS_ROOT: if (cnt_r == 5'd0) state_nxt = pehp_pkg::NS_IDLE;
      default:           state_nxt = pehp_pkg::NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pehp_pkg::NS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == pehp_pkg::NS_ROOT) && (cnt_r == 5'd0);
      unique case (state_r)
        pehp_pkg::NS_IDLE: cnt_r <= 5'd30;
        pehp_pkg::NS_DIV:  cnt_r <= (cnt_r == 5'd0) ? 5'd15 : cnt_r - 5'd1;
        pehp_pkg::NS_ROOT: cnt_r <= cnt_r - 5'd1;
        default:           cnt_r <= 5'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pehp_pkg::NS_IDLE: begin
        if (start) begin
          l2_r  <= l2;
          rem_r <= {2'b00, sq_a[29:1]};
          dvd_r <= {sq_a[0], 30'd0};
          quo_r <= 31'd0;
        end
      end
      pehp_pkg::NS_DIV: begin
        rem_r <= div_ge ? 31'(div_t - {1'b0, l2_r}) : div_t[30:0];
        dvd_r <= {dvd_r[29:0], 1'b0};
        quo_r <= {quo_r[29:0], div_ge};
        if (cnt_r == 5'd0) begin
          op_r  <= {1'b0, quo_r[29:0], div_ge};
          res_r <= 32'd0;
          one_r <= 32'h4000_0000;
        end
      end
      pehp_pkg::NS_ROOT: begin
        if (rt_ge) op_r <= op_r - rt_sum;
        res_r <= res_step;
        one_r <= one_r >> 2;
        if (cnt_r == 5'd0) mag_r <= res_inc[15:1];
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign mag  = mag_r;

endmodule

// ===== hw/rtl/polygon_edge_half_planes_core.sv =====
// Top level of the polygon edge half-plane core: vertex store, area sum and edge sequencer.
`timescale 1ns / 1ps
// Usage: each vertex arrives as one transaction on the in_ channel (Q16.8 x and y, with
// in_last_vertex on the final one). Vertices are written into an internal memory while a
// shoelace area sum is kept. After acceptance a vertex goes through the memory write, two
// products, two accumulate steps and a check before the next one is taken; the first
// vertex of a polygon goes straight to the check. On the last vertex the block emits one
// half-plane transaction per edge on the out_ channel, in edge order, with out_last_plane
// on the final one. For each edge the sequencer reads memory, forms the difference and the
// squares, starts the two divide and square-root units (31 quotient and 16 root steps),
// takes three offset steps and loads the output; a short edge skips from the difference
// to the output load. A polygon of fewer than two vertices gives one transaction with
// out_no_planes set. The cfg_ channel writes closed_polygon, which is 1 after reset; a
// write is taken in any cycle and is meant for while the block is idle. One vertex is
// handled at a time: in_ready is low from acceptance until the last result of that vertex
// sits in the output register. The output register holds a result until out_ready, and
// the sequencer waits on it. Reset empties the vertex count and area sum; the memory
// needs no clearing, since only entries written for the current polygon are read.
module polygon_edge_half_planes_core #(
  parameter int MAX_VERTICES = pehp_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pehp_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [pehp_pkg::COORD_W-1:0] in_vertex_y,
  input  logic                               in_last_vertex,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pehp_pkg::NORM_W-1:0]   out_normal_x,
  output logic signed [pehp_pkg::NORM_W-1:0]   out_normal_y,
  output logic signed [pehp_pkg::OFFSET_W-1:0] out_plane_offset,
  output logic                               out_degenerate_edge,
  output logic                               out_no_planes,
  output logic                               out_last_plane,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_closed_polygon
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int XW = pehp_pkg::COORD_W;

  pehp_pkg::core_state_t state_r, state_nxt;

  logic [2*XW-1:0] mem [MAX_VERTICES];
  logic [2*XW-1:0] rdata_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] edges_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] idx_inc;
  logic          closed_r;
  logic          last_r;
  logic          closing_r;
  logic          fac_neg_r;
  logic          np_r;
  logic signed [pehp_pkg::AREA_W-1:0] acc_r;
  logic signed [2*XW-1:0] prod_r;

  logic signed [XW-1:0] vin_x_r, vin_y_r;
  logic signed [XW-1:0] first_x_r, first_y_r;
  logic signed [XW-1:0] prev_x_r, prev_y_r;
  logic signed [XW-1:0] curr_x_r, curr_y_r;
  logic signed [XW-1:0] next_x_r, next_y_r;

  logic [pehp_pkg::MAG_W-1:0] ax_r, ay_r;
  logic lx_pos_r, ly_neg_r;
  logic [pehp_pkg::SQ_W-1:0] sqx_r, sqy_r;
  logic [pehp_pkg::L2_W-1:0] l2;

  logic signed [pehp_pkg::NORM_W-1:0] res_nx_r, res_ny_r;
  logic signed [pehp_pkg::OFFSET_W-1:0] res_off_r;
  logic res_deg_r;
  logic signed [XW+pehp_pkg::NORM_W-1:0] op1_r, op2_r;

  logic out_valid_r;
  logic signed [pehp_pkg::NORM_W-1:0] out_nx_r, out_ny_r;
  logic signed [pehp_pkg::OFFSET_W-1:0] out_off_r;
  logic out_deg_r, out_np_r, out_last_r;

  pehp_pkg::norm_ctl_t nctl;
  logic [pehp_pkg::MAG_W-1:0] mag_x, mag_y;
  logic done_x;
  logic done_y;

  logic in_acc;
  logic slot_free;
  logic final_res;
  logic has_next;

  logic signed [XW-1:0] opnd_x, opnd_y;
  logic signed [XW-1:0] mul_a, mul_b;
  logic signed [XW-1:0] nv_x, nv_y;
  logic signed [XW:0]   dx, dy;
  logic signed [XW+1:0] lx, ly;
  logic [XW:0] ax_full, ay_full, or_full;
  logic [3:0] shamt;
  logic [XW:0] ax_sh, ay_sh;
  logic small_edge;
  logic signed [XW+pehp_pkg::NORM_W:0] off_sum;

  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign idx_inc   = idx_r + CW'(1);
  assign has_next  = idx_inc < count_r;
  assign final_res = np_r || (idx_inc == edges_r);
  assign l2        = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    in_ready   = state_r == pehp_pkg::ST_IDLE;
    cfg_ready  = 1'b1;
    nctl.start = state_r == pehp_pkg::ST_NORM_GO;
    nctl.done  = done_x && done_y;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pehp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (count_r != '0 && count_r < CW'(MAX_VERTICES)) state_nxt = pehp_pkg::ST_AREA1;
          else state_nxt = pehp_pkg::ST_CHECK;
        end
      end
      pehp_pkg::ST_CHECK: begin
        priority if (!last_r) state_nxt = pehp_pkg::ST_IDLE;
        else if (count_r < CW'(2)) state_nxt = pehp_pkg::ST_OUT;
        else state_nxt = pehp_pkg::ST_AREA1;
      end
      pehp_pkg::ST_AREA1: state_nxt = pehp_pkg::ST_AREA2;
      pehp_pkg::ST_AREA2: state_nxt = pehp_pkg::ST_AREA3;
      pehp_pkg::ST_AREA3: state_nxt = closing_r ? pehp_pkg::ST_SETUP : pehp_pkg::ST_CHECK;
      pehp_pkg::ST_SETUP: state_nxt = pehp_pkg::ST_READ;
      pehp_pkg::ST_READ:  state_nxt = pehp_pkg::ST_DIFF;
      pehp_pkg::ST_DIFF:  state_nxt = small_edge ? pehp_pkg::ST_OUT : pehp_pkg::ST_SQ;
      pehp_pkg::ST_SQ:    state_nxt = pehp_pkg::ST_NORM_GO;
      pehp_pkg::ST_NORM_GO: state_nxt = pehp_pkg::ST_NORM_WAIT;
      pehp_pkg::ST_NORM_WAIT: if (nctl.done) state_nxt = pehp_pkg::ST_OFF1;
      pehp_pkg::ST_OFF1:  state_nxt = pehp_pkg::ST_OFF2;
      pehp_pkg::ST_OFF2:  state_nxt = pehp_pkg::ST_OFF3;
      pehp_pkg::ST_OFF3:  state_nxt = pehp_pkg::ST_OUT;
      pehp_pkg::ST_OUT: begin
        if (slot_free) state_nxt = final_res ? pehp_pkg::ST_IDLE : pehp_pkg::ST_READ;
      end
      default: state_nxt = pehp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    opnd_x = closing_r ? first_x_r : vin_x_r;
    opnd_y = closing_r ? first_y_r : vin_y_r;
    mul_a  = (state_r == pehp_pkg::ST_AREA1) ? prev_x_r : opnd_x;
    mul_b  = (state_r == pehp_pkg::ST_AREA1) ? opnd_y : prev_y_r;
  end

  always_comb begin
    nv_x    = has_next ? $signed(rdata_r[2*XW-1:XW]) : first_x_r;
    nv_y    = has_next ? $signed(rdata_r[XW-1:0]) : first_y_r;
    dx      = (XW+1)'(nv_x) - (XW+1)'(curr_x_r);
    dy      = (XW+1)'(nv_y) - (XW+1)'(curr_y_r);
    lx      = fac_neg_r ? -(XW+2)'(dx) : (XW+2)'(dx);
    ly      = fac_neg_r ? -(XW+2)'(dy) : (XW+2)'(dy);
    ax_full = lx[XW+1] ? (XW+1)'(-lx) : lx[XW:0];
    ay_full = ly[XW+1] ? (XW+1)'(-ly) : ly[XW:0];
    or_full = ax_full | ay_full;
    shamt   = 4'd0;
    for (int b = pehp_pkg::MAG_W; b <= XW; b++) begin
      if (or_full[b]) shamt = 4'(b - pehp_pkg::MAG_W + 1);
    end
    ax_sh = ax_full >> shamt;
    ay_sh = ay_full >> shamt;
    small_edge = (ax_full <= (XW+1)'(2)) && (ay_full <= (XW+1)'(2)) &&
                 !((ax_full == (XW+1)'(2)) && (ay_full == (XW+1)'(2)));
  end

  assign off_sum = (XW+pehp_pkg::NORM_W+1)'(op1_r) + (XW+pehp_pkg::NORM_W+1)'(op2_r)
                 + (XW+pehp_pkg::NORM_W+1)'(8192);

  always_ff @(posedge clk) begin
    if (in_acc && count_r < CW'(MAX_VERTICES)) begin
      mem[count_r[AW-1:0]] <= {in_vertex_x, in_vertex_y};
    end
    if (state_r == pehp_pkg::ST_READ) begin
      rdata_r <= mem[idx_inc[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pehp_pkg::ST_IDLE;
      count_r     <= '0;
      acc_r       <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      closed_r    <= 1'b1;
      out_valid_r <= 1'b0;
      closing_r   <= 1'b0;
      np_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) closed_r <= cfg_closed_polygon;
      if (state_r == pehp_pkg::ST_OUT && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        pehp_pkg::ST_IDLE: begin
          if (in_acc) begin
            closing_r <= 1'b0;
            np_r      <= 1'b0;
            if (count_r < CW'(MAX_VERTICES)) begin
              count_r <= count_r + CW'(1);
              if (count_r == '0) begin
                first_x_r <= in_vertex_x;
                first_y_r <= in_vertex_y;
              end
            end
          end
        end
        pehp_pkg::ST_CHECK: begin
          if (last_r && count_r < CW'(2)) np_r <= 1'b1;
          else if (last_r) closing_r <= 1'b1;
        end
        pehp_pkg::ST_AREA2: acc_r <= acc_r + pehp_pkg::AREA_W'(prod_r);
        pehp_pkg::ST_AREA3: acc_r <= acc_r - pehp_pkg::AREA_W'(prod_r);
        pehp_pkg::ST_OUT: begin
          if (slot_free && final_res) begin
            count_r <= '0;
            acc_r   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pehp_pkg::ST_IDLE: begin
        if (in_acc) begin
          vin_x_r <= in_vertex_x;
          vin_y_r <= in_vertex_y;
          last_r  <= in_last_vertex;
          if (count_r == '0) begin
            prev_x_r <= in_vertex_x;
            prev_y_r <= in_vertex_y;
          end
        end
      end
      pehp_pkg::ST_CHECK: begin
        res_nx_r  <= '0;
        res_ny_r  <= '0;
        res_off_r <= '0;
        res_deg_r <= 1'b0;
      end
      pehp_pkg::ST_AREA1: prod_r <= mul_a * mul_b;
      pehp_pkg::ST_AREA2: prod_r <= mul_a * mul_b;
      pehp_pkg::ST_AREA3: begin
        if (!closing_r) begin
          prev_x_r <= vin_x_r;
          prev_y_r <= vin_y_r;
        end
      end
      pehp_pkg::ST_SETUP: begin
        fac_neg_r <= acc_r > 0;
        edges_r   <= closed_r ? count_r : count_r - CW'(1);
        idx_r     <= '0;
        curr_x_r  <= first_x_r;
        curr_y_r  <= first_y_r;
      end
      pehp_pkg::ST_DIFF: begin
        next_x_r  <= nv_x;
        next_y_r  <= nv_y;
        ax_r      <= ax_sh[pehp_pkg::MAG_W-1:0];
        ay_r      <= ay_sh[pehp_pkg::MAG_W-1:0];
        lx_pos_r  <= !lx[XW+1] && (lx != '0);
        ly_neg_r  <= ly[XW+1];
        res_deg_r <= small_edge;
        res_nx_r  <= '0;
        res_ny_r  <= '0;
        res_off_r <= '0;
      end
      pehp_pkg::ST_SQ: begin
        sqx_r <= ax_r * ax_r;
        sqy_r <= ay_r * ay_r;
      end
      pehp_pkg::ST_NORM_WAIT: begin
        if (nctl.done) begin
          res_nx_r <= ly_neg_r ? -pehp_pkg::NORM_W'(mag_x) : pehp_pkg::NORM_W'(mag_x);
          res_ny_r <= lx_pos_r ? -pehp_pkg::NORM_W'(mag_y) : pehp_pkg::NORM_W'(mag_y);
        end
      end
      pehp_pkg::ST_OFF1: op1_r <= res_nx_r * curr_x_r;
      pehp_pkg::ST_OFF2: op2_r <= res_ny_r * curr_y_r;
      pehp_pkg::ST_OFF3: res_off_r <= pehp_pkg::OFFSET_W'(off_sum >>> 14);
      pehp_pkg::ST_OUT: begin
        if (slot_free) begin
          out_nx_r   <= res_nx_r;
          out_ny_r   <= res_ny_r;
          out_off_r  <= res_off_r;
          out_deg_r  <= res_deg_r;
          out_np_r   <= np_r;
          out_last_r <= final_res;
          idx_r      <= idx_inc;
          curr_x_r   <= next_x_r;
          curr_y_r   <= next_y_r;
        end
      end
      default: ;
    endcase
  end

  pehp_norm u_norm_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nctl.start),
    .sq_a  (sqy_r),
    .l2    (l2),
    .done  (done_x),
    .mag   (mag_x)
  );

  pehp_norm u_norm_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nctl.start),
    .sq_a  (sqx_r),
    .l2    (l2),
    .done  (done_y),
    .mag   (mag_y)
  );

  assign out_valid           = out_valid_r;
  assign out_normal_x        = out_nx_r;
  assign out_normal_y        = out_ny_r;
  assign out_plane_offset    = out_off_r;
  assign out_degenerate_edge = out_deg_r;
  assign out_no_planes       = out_np_r;
  assign out_last_plane      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES))
    else $error("vertex count exceeds the store depth");

  a_np_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_planes |-> out_last_plane && !out_degenerate_edge)
    else $error("empty-polygon result is not the final one");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate_edge |-> out_normal_x == '0 && out_normal_y == '0 &&
                                        out_plane_offset == '0)
    else $error("degenerate edge carries a nonzero plane");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second vertex taken while the first is in work");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the polygon edge half-plane core.
`timescale 1ns / 1ps
module testbench;

  localparam int STORE_DEPTH = pehp_pkg::MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 120;

  typedef struct {
    logic signed [pehp_pkg::COORD_W-1:0] x;
    logic signed [pehp_pkg::COORD_W-1:0] y;
    bit last;
  } vertex_t;

  typedef struct {
    logic signed [pehp_pkg::NORM_W-1:0] nx;
    logic signed [pehp_pkg::NORM_W-1:0] ny;
    logic signed [pehp_pkg::OFFSET_W-1:0] offset;
    bit degenerate;
    bit none;
    bit last;
  } plane_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [pehp_pkg::COORD_W-1:0] in_vertex_x;
  logic signed [pehp_pkg::COORD_W-1:0] in_vertex_y;
  logic in_last_vertex;
  logic out_valid;
  logic out_ready;
  logic signed [pehp_pkg::NORM_W-1:0] out_normal_x;
  logic signed [pehp_pkg::NORM_W-1:0] out_normal_y;
  logic signed [pehp_pkg::OFFSET_W-1:0] out_plane_offset;
  logic out_degenerate_edge;
  logic out_no_planes;
  logic out_last_plane;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_closed_polygon;

  vertex_t pending_vertices[$];
  plane_t expected_planes[$];
  longint poly_x[STORE_DEPTH];
  longint poly_y[STORE_DEPTH];
  int unsigned poly_count = 0;
  longint shoelace_sum = 0;
  longint first_x = 0;
  longint first_y = 0;
  bit closed_mode;
  int send_idle;
  int recv_idle;
  int error_count = 0;
  int planes_seen = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  longint cycle_count = 0;

  polygon_edge_half_planes_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_plane_offset(out_plane_offset), .out_degenerate_edge(out_degenerate_edge),
    .out_no_planes(out_no_planes), .out_last_plane(out_last_plane),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_closed_polygon(cfg_closed_polygon)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unit_component(longint a, longint len2);
    longint lo;
    longint hi;
    longint mid;
    longint q;
    longint rhs;
    lo = 0;
    hi = 16384;
    rhs = (a * a) <<< 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      q = 2 * mid - 1;
      if (q * q * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic plane_t edge_half_plane(longint cx, longint cy, longint nx_pt,
                                             longint ny_pt, longint dir, bit last);
    plane_t p;
    longint lx;
    longint ly;
    longint ax;
    longint ay;
    longint len2;
    longint nrm_x;
    longint nrm_y;
    longint t;
    longint d;
    lx = dir * (nx_pt - cx);
    ly = dir * (ny_pt - cy);
    ax = lx < 0 ? -lx : lx;
    ay = ly < 0 ? -ly : ly;
    p = '{nx: 0, ny: 0, offset: 0, degenerate: 1'b0, none: 1'b0, last: last};
    len2 = ax * ax + ay * ay;
    if (len2 <= 6) begin
      p.degenerate = 1'b1;
      return p;
    end
    while ((ax | ay) >= 32768) begin
      ax = ax >>> 1;
      ay = ay >>> 1;
    end
    len2 = ax * ax + ay * ay;
    nrm_x = unit_component(ay, len2);
    if (ly < 0) nrm_x = -nrm_x;
    nrm_y = unit_component(ax, len2);
    if (lx > 0) nrm_y = -nrm_y;
    t = nrm_x * cx + nrm_y * cy + 8192;
    if (t >= 0) d = t >>> 14;
    else d = -(((-t) + 16383) >>> 14);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    p.nx = nrm_x[pehp_pkg::NORM_W-1:0];
    p.ny = nrm_y[pehp_pkg::NORM_W-1:0];
    p.offset = d[pehp_pkg::OFFSET_W-1:0];
    return p;
  endfunction

  task automatic predict_planes(vertex_t v);
    longint vx;
    longint vy;
    longint dir;
    int unsigned edge_total;
    int unsigned j;
    plane_t p;
    vx = longint'(v.x);
    vy = longint'(v.y);
    if (poly_count < STORE_DEPTH) begin
      if (poly_count == 0) begin
        first_x = vx;
        first_y = vy;
      end else begin
        shoelace_sum += poly_x[poly_count-1] * vy - vx * poly_y[poly_count-1];
      end
      poly_x[poly_count] = vx;
      poly_y[poly_count] = vy;
      poly_count++;
    end
    if (!v.last) return;
    if (poly_count < 2) begin
      p = '{nx: 0, ny: 0, offset: 0, degenerate: 1'b0, none: 1'b1, last: 1'b1};
      expected_planes = {expected_planes, p};
    end else begin
      shoelace_sum += poly_x[poly_count-1] * first_y - first_x * poly_y[poly_count-1];
      dir = shoelace_sum > 0 ? -1 : 1;
      edge_total = closed_mode ? poly_count : poly_count - 1;
      for (int unsigned i = 0; i < edge_total; i++) begin
        j = (i + 1 < poly_count) ? i + 1 : 0;
        p = edge_half_plane(poly_x[i], poly_y[i], poly_x[j], poly_y[j], dir,
                            i + 1 == edge_total);
        expected_planes = {expected_planes, p};
      end
    end
    poly_count = 0;
    shoelace_sum = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("Mismatch on result %0d: %s got %0d, expected %0d", planes_seen, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_vertex_x <= '0;
      in_vertex_y <= '0;
      in_last_vertex <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_planes('{x: in_vertex_x, y: in_vertex_y, last: in_last_vertex});
      if (!in_valid || in_ready) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle) begin
          vertex_t v;
          v = pending_vertices.pop_front();
          in_vertex_x <= v.x;
          in_vertex_y <= v.y;
          in_last_vertex <= v.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_planes.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          plane_t e;
          e = expected_planes.pop_front();
          if (out_normal_x !== e.nx) report_mismatch("normal_x", out_normal_x, e.nx);
          if (out_normal_y !== e.ny) report_mismatch("normal_y", out_normal_y, e.ny);
          if (out_plane_offset !== e.offset)
            report_mismatch("plane_offset", out_plane_offset, e.offset);
          if (out_degenerate_edge !== e.degenerate)
            report_mismatch("degenerate_edge", out_degenerate_edge, e.degenerate);
          if (out_no_planes !== e.none) report_mismatch("no_planes", out_no_planes, e.none);
          if (out_last_plane !== e.last)
            report_mismatch("last_plane", out_last_plane, e.last);
        end
        planes_seen++;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_done && planes_seen == 40) begin
      stall_left <= 600;
      stall_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [pehp_pkg::COORD_W-1:0] random_coord(bit full_range);
    if (full_range) return pehp_pkg::COORD_W'($urandom());
    return pehp_pkg::COORD_W'($urandom_range(8000) - 4000);
  endfunction

  task automatic push_vertex(longint x, longint y, bit last);
    vertex_t v;
    v.x = x[pehp_pkg::COORD_W-1:0];
    v.y = y[pehp_pkg::COORD_W-1:0];
    v.last = last;
    pending_vertices = {pending_vertices, v};
  endtask

  task automatic push_random_polygon(int count, bit full_range);
    longint x;
    longint y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0 && i > 0) begin
        x = longint'(pending_vertices[$].x) + $urandom_range(2);
        y = longint'(pending_vertices[$].y) + $urandom_range(2);
        if (x > 8388607) x = 8388607;
        if (y > 8388607) y = 8388607;
      end else begin
        x = random_coord(full_range);
        y = random_coord(full_range);
      end
      push_vertex(x, y, i == count - 1);
    end
  endtask

  task automatic wait_until_idle();
    wait (pending_vertices.size() == 0 && !in_valid && expected_planes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_closed_mode(bit value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_closed_polygon <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    closed_mode = value;
  endtask

  task automatic run_random(int items);
    int sent;
    int count;
    sent = 0;
    while (sent < items) begin
      count = $urandom_range(7) + 1;
      push_random_polygon(count, $urandom_range(3) == 0);
      sent += count;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_closed_polygon = 1'b1;
    closed_mode = 1'b1;
    send_idle = 29;
    recv_idle = 72;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_vertex(5, -7, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(2560, 0, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(2560, 0, 1'b0);
    push_vertex(0, 2560, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(0, 2560, 1'b0);
    push_vertex(2560, 0, 1'b1);
    push_vertex(8388607, 8388607, 1'b0);
    push_vertex(-8388608, -8388608, 1'b0);
    push_vertex(8388607, -8388608, 1'b0);
    push_vertex(-8388608, 8388607, 1'b1);
    push_vertex(100, 100, 1'b0);
    push_vertex(101, 102, 1'b0);
    push_vertex(103, 103, 1'b0);
    push_vertex(100, 100, 1'b1);
    run_random(RANDOM_ITEMS / 3);
    wait_until_idle();

    write_closed_mode(1'b0);
    send_idle = 72;
    recv_idle = 29;
    push_vertex(0, 0, 1'b0);
    push_vertex(-8388608, 8388607, 1'b0);
    push_vertex(8388607, 0, 1'b1);
    run_random(RANDOM_ITEMS / 3);
    wait_until_idle();

    write_closed_mode(1'b1);
    send_idle = 0;
    recv_idle = 0;
    push_random_polygon(STORE_DEPTH + 3, 1'b0);
    run_random(RANDOM_ITEMS / 3);
    wait_until_idle();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== polygon_edge_half_planes_core.f =====
hw/rtl/pehp_pkg.sv
hw/rtl/pehp_norm.sv
hw/rtl/polygon_edge_half_planes_core.sv
bench/testbench.sv
